[rtl/core/esc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_pkg
// Types and constants shared by the epoch seconds to calendar converter.
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam int unsigned IN_W    = 38;
    localparam int unsigned YEAR_W  = 14;

    localparam int unsigned EPOCH_YEAR = 1970;
    localparam int unsigned LAST_YEAR  = 9999;

    localparam logic [1:0] EPOCH_MOD4   = 2'(EPOCH_YEAR % 4);
    localparam logic [6:0] EPOCH_MOD100 = 7'(EPOCH_YEAR % 100);
    localparam logic [8:0] EPOCH_MOD400 = 9'(EPOCH_YEAR % 400);

    localparam logic [IN_W-1:0] SECS_PER_MINUTE  = IN_W'(60);
    localparam logic [IN_W-1:0] SECS_PER_HOUR    = IN_W'(60 * 60);
    localparam logic [IN_W-1:0] SECS_PER_DAY     = IN_W'(24 * 60 * 60);
    localparam logic [IN_W-1:0] SECS_COMMON_YEAR = IN_W'(365 * 24 * 60 * 60);
    localparam logic [IN_W-1:0] SECS_LEAP_YEAR   = IN_W'(366 * 24 * 60 * 60);

    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_YEAR,
        ST_MONTH,
        ST_DAY,
        ST_HOUR,
        ST_MINUTE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic     load;
        logic     year_step;
        logic     mark_over;
        logic     month_step;
        logic     day_step;
        logic     hour_step;
        logic     minute_step;
        logic     finish;
    } esc_cmd_t;

    typedef struct packed {
        logic year_stop;
        logic over;
        logic month_stop;
        logic day_stop;
        logic hour_stop;
        logic minute_stop;
    } esc_status_t;

    function automatic logic [IN_W-1:0] month_secs(logic [3:0] m, logic leap);
        logic [IN_W-1:0] secs;
        unique case (m)
            MONTH_FEB:
            begin
                secs = leap ? IN_W'(29 * 24 * 60 * 60) : IN_W'(28 * 24 * 60 * 60);
            end
            4'd4, 4'd6, 4'd9, 4'd11:     secs = IN_W'(30 * 24 * 60 * 60);
            default:                     secs = IN_W'(31 * 24 * 60 * 60);
        endcase
        return secs;
    endfunction

endpackage

[rtl/core/esc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_datapath
// Year, month, day, hour and minute subtraction loops on the second count
// and the result registers.
// ----------------------------------------------------------------------------
module esc_datapath (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [esc_pkg::IN_W-1:0]    epoch_seconds,
    input  esc_pkg::esc_cmd_t           cmd,
    output esc_pkg::esc_status_t        status,
    output logic [5:0]                  second_of_minute,
    output logic [5:0]                  minute_of_hour,
    output logic [4:0]                  hour_of_day,
    output logic [4:0]                  day_of_month,
    output logic [3:0]                  month_of_year,
    output logic [esc_pkg::YEAR_W-1:0]  full_year,
    output logic                        out_of_range
);

    logic [esc_pkg::IN_W-1:0]   secs_reg;
    logic [esc_pkg::YEAR_W-1:0] year_reg;
    logic [1:0]                 mod4_reg;
    logic [6:0]                 mod100_reg;
    logic [8:0]                 mod400_reg;
    logic [3:0]                 mon_reg;
    logic [4:0]                 day_reg;
    logic [4:0]                 hour_reg;
    logic [5:0]                 min_reg;
    logic                       over_reg;

    logic [5:0]                 sec_out_reg;
    logic [5:0]                 min_out_reg;
    logic [4:0]                 hour_out_reg;
    logic [4:0]                 day_out_reg;
    logic [3:0]                 mon_out_reg;
    logic [esc_pkg::YEAR_W-1:0] year_out_reg;
    logic                       oor_out_reg;

    logic                       leap;
    logic [esc_pkg::IN_W-1:0]   year_secs;
    logic [esc_pkg::IN_W-1:0]   mon_secs;

    assign leap      = ((mod4_reg == 2'd0) && (mod100_reg != 7'd0)) || (mod400_reg == 9'd0);
    assign year_secs = leap ? esc_pkg::SECS_LEAP_YEAR : esc_pkg::SECS_COMMON_YEAR;
    assign mon_secs  = esc_pkg::month_secs(mon_reg, leap);

    assign status.year_stop   = secs_reg < year_secs;
    assign status.over        = year_reg >= esc_pkg::YEAR_W'(esc_pkg::LAST_YEAR);
    assign status.month_stop  = (mon_reg == esc_pkg::MONTH_DEC) || (secs_reg < mon_secs);
    assign status.day_stop    = secs_reg < esc_pkg::SECS_PER_DAY;
    assign status.hour_stop   = secs_reg < esc_pkg::SECS_PER_HOUR;
    assign status.minute_stop = secs_reg < esc_pkg::SECS_PER_MINUTE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            secs_reg     <= '0;
            year_reg     <= '0;
            mod4_reg     <= 2'd0;
            mod100_reg   <= 7'd0;
            mod400_reg   <= 9'd0;
            mon_reg      <= 4'd0;
            day_reg      <= 5'd0;
            hour_reg     <= 5'd0;
            min_reg      <= 6'd0;
            over_reg     <= 1'b0;
            sec_out_reg  <= 6'd0;
            min_out_reg  <= 6'd0;
            hour_out_reg <= 5'd0;
            day_out_reg  <= 5'd0;
            mon_out_reg  <= 4'd0;
            year_out_reg <= '0;
            oor_out_reg  <= 1'b0;
        end
        else if (cmd.load)
        begin
            secs_reg   <= epoch_seconds;
            year_reg   <= esc_pkg::YEAR_W'(esc_pkg::EPOCH_YEAR);
            mod4_reg   <= esc_pkg::EPOCH_MOD4;
            mod100_reg <= esc_pkg::EPOCH_MOD100;
            mod400_reg <= esc_pkg::EPOCH_MOD400;
            mon_reg    <= 4'd1;
            day_reg    <= 5'd1;
            hour_reg   <= 5'd0;
            min_reg    <= 6'd0;
            over_reg   <= 1'b0;
        end
        else if (cmd.year_step)
        begin
            secs_reg   <= secs_reg - year_secs;
            year_reg   <= year_reg + 1'b1;
            mod4_reg   <= mod4_reg + 2'd1;
            mod100_reg <= (mod100_reg == 7'd99) ? 7'd0 : mod100_reg + 7'd1;
            mod400_reg <= (mod400_reg == 9'd399) ? 9'd0 : mod400_reg + 9'd1;
        end
        else if (cmd.mark_over)
        begin
            over_reg <= 1'b1;
        end
        else if (cmd.month_step)
        begin
            secs_reg <= secs_reg - mon_secs;
            mon_reg  <= mon_reg + 4'd1;
        end
        else if (cmd.day_step)
        begin
            secs_reg <= secs_reg - esc_pkg::SECS_PER_DAY;
            day_reg  <= day_reg + 5'd1;
        end
        else if (cmd.hour_step)
        begin
            secs_reg <= secs_reg - esc_pkg::SECS_PER_HOUR;
            hour_reg <= hour_reg + 5'd1;
        end
        else if (cmd.minute_step)
        begin
            secs_reg <= secs_reg - esc_pkg::SECS_PER_MINUTE;
            min_reg  <= min_reg + 6'd1;
        end
        else if (cmd.finish)
        begin
            if (over_reg)
            begin
                sec_out_reg  <= 6'd0;
                min_out_reg  <= 6'd0;
                hour_out_reg <= 5'd0;
                day_out_reg  <= 5'd0;
                mon_out_reg  <= 4'd0;
                year_out_reg <= '0;
                oor_out_reg  <= 1'b1;
            end
            else
            begin
                sec_out_reg  <= secs_reg[5:0];
                min_out_reg  <= min_reg;
                hour_out_reg <= hour_reg;
                day_out_reg  <= day_reg;
                mon_out_reg  <= mon_reg;
                year_out_reg <= year_reg;
                oor_out_reg  <= 1'b0;
            end
        end
    end

    assign second_of_minute = sec_out_reg;
    assign minute_of_hour   = min_out_reg;
    assign hour_of_day      = hour_out_reg;
    assign day_of_month     = day_out_reg;
    assign month_of_year    = mon_out_reg;
    assign full_year        = year_out_reg;
    assign out_of_range     = oor_out_reg;

endmodule

[rtl/core/esc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_ctrl
// Sequencer for the converter: the year, month, day, hour and minute loops
// and the result strobe.
// ----------------------------------------------------------------------------
module esc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  esc_pkg::esc_status_t  status,
    output esc_pkg::esc_cmd_t     cmd,
    output logic                  busy,
    output logic                  done
);

    esc_pkg::state_t              state_reg;
    esc_pkg::state_t              state_next;
    logic                         done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= esc_pkg::ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= cmd.finish;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            esc_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = esc_pkg::ST_YEAR;
                end
            end
            esc_pkg::ST_YEAR:
            begin
                if (status.year_stop)
                begin
                    state_next = esc_pkg::ST_MONTH;
                end
                else if (status.over)
                begin
                    state_next = esc_pkg::ST_FINISH;
                end
            end
            esc_pkg::ST_MONTH:
            begin
                if (status.month_stop)
                begin
                    state_next = esc_pkg::ST_DAY;
                end
            end
            esc_pkg::ST_DAY:
            begin
                if (status.day_stop)
                begin
                    state_next = esc_pkg::ST_HOUR;
                end
            end
            esc_pkg::ST_HOUR:
            begin
                if (status.hour_stop)
                begin
                    state_next = esc_pkg::ST_MINUTE;
                end
            end
            esc_pkg::ST_MINUTE:
            begin
                if (status.minute_stop)
                begin
                    state_next = esc_pkg::ST_FINISH;
                end
            end
            esc_pkg::ST_FINISH:
            begin
                state_next = esc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = esc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            esc_pkg::ST_IDLE:   cmd.load = start;
            esc_pkg::ST_YEAR:
            begin
                cmd.year_step = !status.year_stop && !status.over;
                cmd.mark_over = !status.year_stop && status.over;
            end
            esc_pkg::ST_MONTH:  cmd.month_step  = !status.month_stop;
            esc_pkg::ST_DAY:    cmd.day_step    = !status.day_stop;
            esc_pkg::ST_HOUR:   cmd.hour_step   = !status.hour_stop;
            esc_pkg::ST_MINUTE: cmd.minute_step = !status.minute_stop;
            esc_pkg::ST_FINISH: cmd.finish      = 1'b1;
            default: ;
        endcase
    end

    assign busy = state_reg != esc_pkg::ST_IDLE;
    assign done = done_reg;

endmodule

[rtl/core/epoch_seconds_to_calendar_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_core
// Converts seconds since 1970-01-01 00:00:00 to Gregorian date and time.
// ----------------------------------------------------------------------------
// A transaction starts when start is high while busy is low. The result
// appears on the output ports with done, a one-cycle strobe, in the first
// cycle after busy falls, and must be captured then: the receiver cannot
// stall the block. The second count is reduced by one year, month, day, hour
// or minute per cycle, and busy stays high while these loops run; the year
// loop can take by far the most steps. Past 9999-12-31 out_of_range is set
// and every other field is zero. A new start may be accepted in the done
// cycle. Outputs hold their last result until the next done.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [esc_pkg::IN_W-1:0]    epoch_seconds,
    output logic                        done,
    output logic [5:0]                  second_of_minute,
    output logic [5:0]                  minute_of_hour,
    output logic [4:0]                  hour_of_day,
    output logic [4:0]                  day_of_month,
    output logic [3:0]                  month_of_year,
    output logic [esc_pkg::YEAR_W-1:0]  full_year,
    output logic                        out_of_range
);

    esc_pkg::esc_cmd_t    cmd;
    esc_pkg::esc_status_t status;

    esc_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    esc_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .epoch_seconds    (epoch_seconds),
        .cmd              (cmd),
        .status           (status),
        .second_of_minute (second_of_minute),
        .minute_of_hour   (minute_of_hour),
        .hour_of_day      (hour_of_day),
        .day_of_month     (day_of_month),
        .month_of_year    (month_of_year),
        .full_year        (full_year),
        .out_of_range     (out_of_range)
    );

endmodule

[rtl/core/esc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// esc_checker
// Port-level checks on the converter, bound to the top level.
// ----------------------------------------------------------------------------
module esc_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic [5:0]                  second_of_minute,
    input logic [5:0]                  minute_of_hour,
    input logic [4:0]                  hour_of_day,
    input logic [4:0]                  day_of_month,
    input logic [3:0]                  month_of_year,
    input logic [esc_pkg::YEAR_W-1:0]  full_year,
    input logic                        out_of_range
);

    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe repeated");

    a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
        done && !out_of_range |-> second_of_minute < 6'd60 && minute_of_hour < 6'd60
            && hour_of_day < 5'd24 && day_of_month != 5'd0
            && month_of_year != 4'd0 && month_of_year <= esc_pkg::MONTH_DEC
            && full_year >= esc_pkg::YEAR_W'(esc_pkg::EPOCH_YEAR)
            && full_year <= esc_pkg::YEAR_W'(esc_pkg::LAST_YEAR))
        else $error("result field out of range");

    a_over_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && out_of_range |-> second_of_minute == 6'd0 && minute_of_hour == 6'd0
            && hour_of_day == 5'd0 && day_of_month == 5'd0
            && month_of_year == 4'd0 && full_year == '0)
        else $error("out of range result has nonzero fields");

endmodule

bind epoch_seconds_to_calendar_core esc_checker u_esc_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .done             (done),
    .second_of_minute (second_of_minute),
    .minute_of_hour   (minute_of_hour),
    .hour_of_day      (hour_of_day),
    .day_of_month     (day_of_month),
    .month_of_year    (month_of_year),
    .full_year        (full_year),
    .out_of_range     (out_of_range)
);

[tb/epoch_seconds_to_calendar_core_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_core_test
// Checks the epoch seconds to calendar converter against a date predictor.
// ----------------------------------------------------------------------------
// Directed transactions cover the time-of-day extremes, the leap-year rules,
// and the edge of the last supported year. Random transactions follow: mostly
// dates near the epoch, well-formed dates around month boundaries, and some
// over the whole 38-bit input. Every result is compared with the oldest
// predicted date. Start is held off in random bursts except at the end.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_core_test;

    typedef struct packed {
        logic                       over;
        logic [esc_pkg::YEAR_W-1:0] yr;
        logic [3:0]                 mon;
        logic [4:0]                 day;
        logic [4:0]                 hr;
        logic [5:0]                 mnt;
        logic [5:0]                 sec;
    } civil_time_t;

    localparam int unsigned DAYS_PER_MONTH [12] =
        '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    logic                        clk;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic [esc_pkg::IN_W-1:0]    epoch_seconds;
    logic                        done;
    logic [5:0]                  second_of_minute;
    logic [5:0]                  minute_of_hour;
    logic [4:0]                  hour_of_day;
    logic [4:0]                  day_of_month;
    logic [3:0]                  month_of_year;
    logic [esc_pkg::YEAR_W-1:0]  full_year;
    logic                        out_of_range;

    civil_time_t pending_dates [$];
    civil_time_t oldest_date;
    int unsigned mismatch_count;
    bit          idle_bursts;

    epoch_seconds_to_calendar_core i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .epoch_seconds    (epoch_seconds),
        .done             (done),
        .second_of_minute (second_of_minute),
        .minute_of_hour   (minute_of_hour),
        .hour_of_day      (hour_of_day),
        .day_of_month     (day_of_month),
        .month_of_year    (month_of_year),
        .full_year        (full_year),
        .out_of_range     (out_of_range)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #25_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic bit is_leap(int unsigned y);
        return ((y % 4) == 0 && (y % 100) != 0) || ((y % 400) == 0);
    endfunction

    function automatic int unsigned days_in_year(int unsigned y);
        return is_leap(y) ? 366 : 365;
    endfunction

    function automatic int unsigned month_days(int unsigned m, int unsigned y);
        return DAYS_PER_MONTH[4'(m - 1)] + ((m == 2 && is_leap(y)) ? 1 : 0);
    endfunction

    function automatic civil_time_t civil_time_of(logic [esc_pkg::IN_W-1:0] secs);
        longint unsigned t;
        int unsigned     days;
        int unsigned     y;
        int unsigned     m;
        civil_time_t     r;
        t = 64'(secs);
        r = '0;
        r.sec = 6'(t % 60);
        t = t / 60;
        r.mnt = 6'(t % 60);
        t = t / 60;
        r.hr = 5'(t % 24);
        days = 32'(t / 24);
        y = esc_pkg::EPOCH_YEAR;
        while (days >= days_in_year(y))
        begin
            if (y >= esc_pkg::LAST_YEAR)
            begin
                r = '0;
                r.over = 1'b1;
                return r;
            end
            days = days - days_in_year(y);
            y++;
        end
        m = 1;
        while (m < 12 && days >= month_days(m, y))
        begin
            days = days - month_days(m, y);
            m++;
        end
        r.day = 5'(days + 1);
        r.mon = 4'(m);
        r.yr  = esc_pkg::YEAR_W'(y);
        return r;
    endfunction

    function automatic longint unsigned seconds_of_date(int unsigned y, int unsigned m,
                                                        int unsigned d, int unsigned h,
                                                        int unsigned mi, int unsigned s);
        int unsigned days;
        days = 0;
        for (int unsigned i = esc_pkg::EPOCH_YEAR; i < y; i++)
            days += days_in_year(i);
        for (int unsigned i = 1; i < m; i++)
            days += month_days(i, y);
        days += d - 1;
        return ((64'(days) * 24 + 64'(h)) * 60 + 64'(mi)) * 60 + 64'(s);
    endfunction

    function automatic longint unsigned rand_below(longint unsigned span);
        longint unsigned r;
        r = {$urandom(), $urandom()};
        return r % span;
    endfunction

    task automatic compare_field(string field, int unsigned want, int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_dates.size() == 0)
            begin
                $display("%0t: result expected none actual %0d-%0d-%0d %0d:%0d:%0d over %0d",
                         $time, full_year, month_of_year, day_of_month, hour_of_day,
                         minute_of_hour, second_of_minute, out_of_range);
                mismatch_count++;
            end
            else
            begin
                oldest_date = pending_dates.pop_front();
                compare_field("second_of_minute", 32'(oldest_date.sec),
                              32'(second_of_minute));
                compare_field("minute_of_hour", 32'(oldest_date.mnt), 32'(minute_of_hour));
                compare_field("hour_of_day", 32'(oldest_date.hr), 32'(hour_of_day));
                compare_field("day_of_month", 32'(oldest_date.day), 32'(day_of_month));
                compare_field("month_of_year", 32'(oldest_date.mon), 32'(month_of_year));
                compare_field("full_year", 32'(oldest_date.yr), 32'(full_year));
                compare_field("out_of_range", 32'(oldest_date.over), 32'(out_of_range));
            end
        end
    end

    task automatic send_seconds(longint unsigned secs);
        if (idle_bursts && $urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 14)) @(negedge clk);
        @(negedge clk);
        start         <= 1'b1;
        epoch_seconds <= esc_pkg::IN_W'(secs);
        do
            @(posedge clk);
        while (busy);
        pending_dates.push_back(civil_time_of(esc_pkg::IN_W'(secs)));
        @(negedge clk);
        start         <= 1'b0;
        epoch_seconds <= {6'($urandom_range(0, 63)), 32'($urandom())};
    endtask

    task automatic drain_results();
        while (pending_dates.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_time_of_day();
        send_seconds(0);
        send_seconds(59);
        send_seconds(60);
        send_seconds(3599);
        send_seconds(3600);
        send_seconds(86399);
        send_seconds(86400);
        drain_results();
    endtask

    task automatic test_leap_rules();
        send_seconds(seconds_of_date(1970, 12, 31, 23, 59, 59));
        send_seconds(seconds_of_date(1971, 1, 1, 0, 0, 0));
        send_seconds(seconds_of_date(1972, 2, 29, 12, 30, 45));
        send_seconds(seconds_of_date(1972, 3, 1, 0, 0, 0));
        send_seconds(seconds_of_date(2000, 2, 29, 23, 59, 59));
        send_seconds(seconds_of_date(2000, 12, 31, 23, 59, 59));
        send_seconds(seconds_of_date(2100, 2, 28, 23, 59, 59));
        send_seconds(seconds_of_date(2100, 3, 1, 0, 0, 0));
        send_seconds(seconds_of_date(2400, 2, 29, 6, 7, 8));
        drain_results();
    endtask

    task automatic test_last_year();
        longint unsigned last_valid;
        last_valid = seconds_of_date(esc_pkg::LAST_YEAR, 12, 31, 23, 59, 59);
        send_seconds(last_valid);
        send_seconds(last_valid + 1);
        send_seconds(64'h20_0000_0000);
        send_seconds(64'h3F_FFFF_FFFF);
        drain_results();
    endtask

    task automatic test_random_dates(int unsigned count, bit bursty);
        longint unsigned near_span;
        longint unsigned last_valid;
        longint unsigned secs;
        int unsigned     y;
        int unsigned     m;
        int unsigned     d;
        idle_bursts = bursty;
        near_span   = seconds_of_date(2100, 1, 1, 0, 0, 0);
        last_valid  = seconds_of_date(esc_pkg::LAST_YEAR, 12, 31, 23, 59, 59);
        repeat (count)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: secs = rand_below(near_span);
                5, 6:
                begin
                    y = ($urandom_range(0, 9) == 0) ? $urandom_range(2131, esc_pkg::LAST_YEAR)
                                                    : $urandom_range(1970, 2130);
                    m = $urandom_range(1, 12);
                    case ($urandom_range(0, 2))
                        0:       d = 1;
                        1:       d = month_days(m, y);
                        default: d = $urandom_range(1, month_days(m, y));
                    endcase
                    secs = seconds_of_date(y, m, d, $urandom_range(0, 23),
                                           $urandom_range(0, 59), $urandom_range(0, 59));
                end
                7:       secs = rand_below(last_valid + 1);
                8:       secs = last_valid + 1 + rand_below(64'h3F_FFFF_FFFF - last_valid);
                default: secs = {$urandom_range(0, 63), $urandom()};
            endcase
            send_seconds(secs);
        end
        drain_results();
    endtask

    initial
    begin
        rst_n          = 1'b0;
        start          = 1'b0;
        epoch_seconds  = '0;
        mismatch_count = 0;
        idle_bursts    = 1'b1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_time_of_day();
        test_leap_rules();
        test_last_year();
        test_random_dates(64, 1'b1);
        test_random_dates(16, 1'b0);

        repeat (8300) @(posedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

[sim.f]
rtl/core/esc_pkg.sv
rtl/core/esc_datapath.sv
rtl/core/esc_ctrl.sv
rtl/core/epoch_seconds_to_calendar_core.sv
rtl/core/esc_checker.sv
tb/epoch_seconds_to_calendar_core_test.sv
